>>> rtl/core/bta_pkg.sv
// shared types and constants for the boundary tag allocator
// no dependencies
`default_nettype none

package bta_pkg;

   localparam int REGION_BYTES_DEF = 4096;
   localparam int TAG_BYTES_DEF    = 17;
   localparam int ELEM_W           = 13;
   localparam int OFFS_W           = 12;
   localparam int BYTES_W          = 13;
   localparam int NEED_W           = 26;
   localparam int MODE_W           = 2;
   localparam int STAT_W           = 2;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_START = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [MODE_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NONE  = 2'd3
   } fit_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_NO_FIT = 2'd1,
      STAT_RANGE  = 2'd2,
      STAT_NO_TAG = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_NEED, ST_ACHK, ST_ARD, ST_AEV, ST_ACMP,
      ST_ABEST, ST_AEND, ST_AENDP, ST_AMID, ST_AHEAD, ST_ATAIL, ST_ANEXT,
      ST_ALAST, ST_FCHK, ST_FRANGE, ST_FEV, ST_FLIM, ST_FPREV, ST_FPCLR,
      ST_FPADD, ST_FNRD, ST_FNEV, ST_FNCLR, ST_FNCLR2, ST_FHEAD, ST_FTAIL,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/bta_ifs.sv
// request, response and register write channels of the allocator
// depends on bta_pkg
`default_nettype none

interface bta_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [bta_pkg::ELEM_W-1:0] elem_size;
   logic [bta_pkg::ELEM_W-1:0] elem_count;
   logic [bta_pkg::OFFS_W-1:0] free_offset;
   modport source (output valid, req_type, elem_size, elem_count, free_offset, input ready);
   modport sink (input valid, req_type, elem_size, elem_count, free_offset, output ready);
endinterface

interface bta_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bta_pkg::STAT_W-1:0]  status;
   logic [bta_pkg::OFFS_W-1:0]  data_offset;
   logic [bta_pkg::BYTES_W-1:0] block_bytes;
   modport source (output valid, status, data_offset, block_bytes, input ready);
   modport sink (input valid, status, data_offset, block_bytes, output ready);
endinterface

interface bta_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bta_pkg::MODE_W-1:0] policy;
   modport source (output valid, policy, input ready);
   modport sink (input valid, policy, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bta_tag_ram.sv
// tag store: one write port, one registered read port
// no dependencies
`default_nettype none

module bta_tag_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16,
   parameter int AW    = 12
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> rtl/core/bta_alu.sv
// shared add / subtract unit with unsigned less-than flag
// depends on bta_pkg
`default_nettype none

module bta_alu #(
   parameter int DW = 26
) (
   input  wire bta_pkg::alu_op_type op,
   input  wire logic [DW-1:0]       a,
   input  wire logic [DW-1:0]       b,
   output logic      [DW-1:0]       res,
   output logic                     lt
);

   logic [DW:0] diff;

   always_comb begin
      diff = {1'b0, a} - {1'b0, b};
      lt   = diff[DW];
      res  = (op == bta_pkg::ALU_ADD) ? a + b : diff[DW-1:0];
   end

endmodule

`default_nettype wire

>>> rtl/core/boundary_tag_allocator.sv
// top level of the boundary tag allocator: sequencer, tag store and shared adder
// depends on bta_pkg, bta_ifs, bta_tag_ram, bta_alu
`default_nettype none

// One request at a time. After reset a clearing pass writes every tag slot
// before the first request is taken; register writes are taken at any time.
// An allocate walks the block chain one block at a time, since every block is
// read through the one read port of the tag store and checked with the one
// shared adder. The response is held until taken, then the next request is
// accepted.
module boundary_tag_allocator #(
   parameter int REGION_BYTES = bta_pkg::REGION_BYTES_DEF,
   parameter int TAG_BYTES    = bta_pkg::TAG_BYTES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   bta_req_if.sink   req_ch,
   bta_rsp_if.source rsp_ch,
   bta_csr_if.sink   csr_ch
);

   localparam int AW     = (REGION_BYTES > 1) ? $clog2(REGION_BYTES) : 1;
   localparam int SIZE_W = $clog2(REGION_BYTES + 1);
   localparam int TW     = SIZE_W + 3;
   localparam int DW     = (bta_pkg::NEED_W > SIZE_W + 1) ? bta_pkg::NEED_W : SIZE_W + 1;
   localparam logic [DW-1:0] D_REGION = DW'(REGION_BYTES);
   localparam logic [DW-1:0] D_TAG    = DW'(TAG_BYTES);
   localparam logic [DW-1:0] D_TAG2   = DW'(2 * TAG_BYTES);
   localparam logic HAS_BLOCK         = (REGION_BYTES >= 2 * TAG_BYTES);

   function automatic logic [TW-1:0] pack(bta_pkg::kind_type k, logic o, logic [DW-1:0] s);
      return {k, o, s[SIZE_W-1:0]};
   endfunction

   bta_pkg::state_type  state_ff, state_in;
   bta_pkg::fit_type    mode_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [bta_pkg::ELEM_W-1:0] esize_ff, esize_in, ecount_ff, ecount_in;
   logic [DW-1:0]       offs_ff, offs_in;
   logic [DW-1:0]       prod_ff, prod_in, need_ff, need_in;
   logic [DW-1:0]       pos_ff, pos_in, nxt_ff, nxt_in, sz_ff, sz_in;
   logic                occ_ff, occ_in, found_ff, found_in;
   logic [DW-1:0]       pick_ff, pick_in, psize_ff, psize_in;
   logic [DW-1:0]       rest_ff, rest_in, endp_ff, endp_in, mid_ff, mid_in;
   logic [DW-1:0]       bytes_ff, bytes_in, dofs_ff, dofs_in;
   logic [DW-1:0]       pe_ff, pe_in, other_ff, other_in;
   bta_pkg::status_type stat_ff, stat_in;
   logic [DW-1:0]       rofs_ff, rofs_in, rbytes_ff, rbytes_in;

   bta_pkg::alu_op_type alu_op;
   logic [DW-1:0]       alu_a, alu_b, alu_res;
   logic                alu_lt;

   logic                we;
   logic [AW-1:0]       waddr, raddr;
   logic [TW-1:0]       wdata, q;
   bta_pkg::kind_type   q_kind;
   logic                q_occ;
   logic [DW-1:0]       q_size;
   logic                split, better;

   bta_tag_ram #(.DEPTH(REGION_BYTES), .WIDTH(TW), .AW(AW)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(q)
   );

   bta_alu #(.DW(DW)) u_alu (
      .op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .lt(alu_lt)
   );

   assign q_kind = bta_pkg::kind_type'(q[TW-1:TW-2]);
   assign q_occ  = q[TW-3];
   assign q_size = DW'(q[SIZE_W-1:0]);

   assign req_ch.ready       = (state_ff == bta_pkg::ST_IDLE);
   assign rsp_ch.valid       = (state_ff == bta_pkg::ST_RESP);
   assign rsp_ch.status      = stat_ff;
   assign rsp_ch.data_offset = rofs_ff[bta_pkg::OFFS_W-1:0];
   assign rsp_ch.block_bytes = rbytes_ff[bta_pkg::BYTES_W-1:0];
   assign csr_ch.ready       = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::ST_CLEAR;
         clr_ff   <= '0;
         mode_ff  <= bta_pkg::FIT_FIRST;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_ch.valid) begin
            mode_ff <= bta_pkg::fit_type'(csr_ch.policy);
         end
      end
   end

   always_ff @(posedge clock) begin
      esize_ff  <= esize_in;
      ecount_ff <= ecount_in;
      offs_ff   <= offs_in;
      prod_ff   <= prod_in;
      need_ff   <= need_in;
      pos_ff    <= pos_in;
      nxt_ff    <= nxt_in;
      sz_ff     <= sz_in;
      occ_ff    <= occ_in;
      found_ff  <= found_in;
      pick_ff   <= pick_in;
      psize_ff  <= psize_in;
      rest_ff   <= rest_in;
      endp_ff   <= endp_in;
      mid_ff    <= mid_in;
      bytes_ff  <= bytes_in;
      dofs_ff   <= dofs_in;
      pe_ff     <= pe_in;
      other_ff  <= other_in;
      stat_ff   <= stat_in;
      rofs_ff   <= rofs_in;
      rbytes_ff <= rbytes_in;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      esize_in  = esize_ff;
      ecount_in = ecount_ff;
      offs_in   = offs_ff;
      prod_in   = prod_ff;
      need_in   = need_ff;
      pos_in    = pos_ff;
      nxt_in    = nxt_ff;
      sz_in     = sz_ff;
      occ_in    = occ_ff;
      found_in  = found_ff;
      pick_in   = pick_ff;
      psize_in  = psize_ff;
      rest_in   = rest_ff;
      endp_in   = endp_ff;
      mid_in    = mid_ff;
      bytes_in  = bytes_ff;
      dofs_in   = dofs_ff;
      pe_in     = pe_ff;
      other_in  = other_ff;
      stat_in   = stat_ff;
      rofs_in   = rofs_ff;
      rbytes_in = rbytes_ff;
      alu_op    = bta_pkg::ALU_ADD;
      alu_a     = '0;
      alu_b     = '0;
      we        = 1'b0;
      waddr     = '0;
      wdata     = '0;
      raddr     = '0;
      split     = (rest_ff >= D_TAG2);
      better    = 1'b0;

      case (state_ff)
         bta_pkg::ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            if (HAS_BLOCK && clr_ff == '0) begin
               wdata = pack(bta_pkg::KIND_START, 1'b0, D_REGION);
            end else if (HAS_BLOCK && clr_ff == AW'(REGION_BYTES - TAG_BYTES)) begin
               wdata = pack(bta_pkg::KIND_END, 1'b0, D_REGION);
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(REGION_BYTES - 1)) begin
               state_in = bta_pkg::ST_IDLE;
            end
         end
         bta_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               esize_in  = req_ch.elem_size;
               ecount_in = req_ch.elem_count;
               offs_in   = DW'(req_ch.free_offset);
               state_in  = (req_ch.req_type == bta_pkg::REQ_FREE) ?
                           bta_pkg::ST_FCHK : bta_pkg::ST_MUL;
            end
         end
         // allocate
         bta_pkg::ST_MUL: begin
            prod_in  = DW'(bta_pkg::NEED_W'(esize_ff) * bta_pkg::NEED_W'(ecount_ff));
            state_in = bta_pkg::ST_NEED;
         end
         bta_pkg::ST_NEED: begin
            alu_a    = prod_ff;
            alu_b    = D_TAG2;
            need_in  = alu_res;
            state_in = bta_pkg::ST_ACHK;
         end
         bta_pkg::ST_ACHK: begin
            alu_op = bta_pkg::ALU_SUB;
            alu_a  = D_REGION;
            alu_b  = need_ff;
            if (alu_lt || mode_ff == bta_pkg::FIT_NONE || !HAS_BLOCK) begin
               stat_in   = bta_pkg::STAT_NO_FIT;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else begin
               pos_in   = '0;
               found_in = 1'b0;
               state_in = bta_pkg::ST_ARD;
            end
         end
         bta_pkg::ST_ARD: begin
            raddr = pos_ff[AW-1:0];
            state_in = (pos_ff >= D_REGION) ? bta_pkg::ST_AEND : bta_pkg::ST_AEV;
         end
         bta_pkg::ST_AEV: begin
            alu_a  = pos_ff;
            alu_b  = q_size;
            nxt_in = alu_res;
            sz_in  = q_size;
            occ_in = q_occ;
            if (q_kind != bta_pkg::KIND_START || q_size < D_TAG2) begin
               state_in = bta_pkg::ST_AEND;
            end else begin
               state_in = bta_pkg::ST_ACMP;
            end
         end
         bta_pkg::ST_ACMP: begin
            alu_op = bta_pkg::ALU_SUB;
            alu_a  = sz_ff;
            alu_b  = need_ff;
            if (nxt_ff > D_REGION) begin
               state_in = bta_pkg::ST_AEND;
            end else if (occ_ff || alu_lt) begin
               pos_in   = nxt_ff;
               state_in = bta_pkg::ST_ARD;
            end else if (!found_ff || mode_ff == bta_pkg::FIT_FIRST) begin
               pick_in  = pos_ff;
               psize_in = sz_ff;
               found_in = 1'b1;
               pos_in   = nxt_ff;
               state_in = (mode_ff == bta_pkg::FIT_FIRST) ? bta_pkg::ST_AEND : bta_pkg::ST_ARD;
            end else begin
               state_in = bta_pkg::ST_ABEST;
            end
         end
         bta_pkg::ST_ABEST: begin
            alu_op = bta_pkg::ALU_SUB;
            alu_a  = (mode_ff == bta_pkg::FIT_BEST) ? sz_ff : psize_ff;
            alu_b  = (mode_ff == bta_pkg::FIT_BEST) ? psize_ff : sz_ff;
            better = alu_lt;
            if (better) begin
               pick_in  = pos_ff;
               psize_in = sz_ff;
            end
            pos_in   = nxt_ff;
            state_in = bta_pkg::ST_ARD;
         end
         bta_pkg::ST_AEND: begin
            alu_op  = bta_pkg::ALU_SUB;
            alu_a   = psize_ff;
            alu_b   = need_ff;
            rest_in = alu_res;
            if (!found_ff) begin
               stat_in   = bta_pkg::STAT_NO_FIT;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else begin
               state_in = bta_pkg::ST_AENDP;
            end
         end
         bta_pkg::ST_AENDP: begin
            alu_a    = pick_ff;
            alu_b    = psize_ff;
            endp_in  = alu_res;
            state_in = bta_pkg::ST_AMID;
         end
         bta_pkg::ST_AMID: begin
            alu_a    = pick_ff;
            alu_b    = need_ff;
            mid_in   = alu_res;
            state_in = bta_pkg::ST_AHEAD;
         end
         bta_pkg::ST_AHEAD: begin
            bytes_in = split ? need_ff : psize_ff;
            we       = 1'b1;
            waddr    = pick_ff[AW-1:0];
            wdata    = pack(bta_pkg::KIND_START, 1'b1, bytes_in);
            alu_a    = pick_ff;
            alu_b    = D_TAG;
            dofs_in  = alu_res;
            state_in = bta_pkg::ST_ATAIL;
         end
         bta_pkg::ST_ATAIL: begin
            alu_op = bta_pkg::ALU_SUB;
            alu_a  = split ? mid_ff : endp_ff;
            alu_b  = D_TAG;
            we     = 1'b1;
            waddr  = alu_res[AW-1:0];
            wdata  = pack(bta_pkg::KIND_END, 1'b1, bytes_ff);
            if (split) begin
               state_in = bta_pkg::ST_ANEXT;
            end else begin
               stat_in   = bta_pkg::STAT_OK;
               rofs_in   = dofs_ff;
               rbytes_in = bytes_ff;
               state_in  = bta_pkg::ST_RESP;
            end
         end
         bta_pkg::ST_ANEXT: begin
            we       = 1'b1;
            waddr    = mid_ff[AW-1:0];
            wdata    = pack(bta_pkg::KIND_START, 1'b0, rest_ff);
            state_in = bta_pkg::ST_ALAST;
         end
         bta_pkg::ST_ALAST: begin
            alu_op    = bta_pkg::ALU_SUB;
            alu_a     = endp_ff;
            alu_b     = D_TAG;
            we        = 1'b1;
            waddr     = alu_res[AW-1:0];
            wdata     = pack(bta_pkg::KIND_END, 1'b0, rest_ff);
            stat_in   = bta_pkg::STAT_OK;
            rofs_in   = dofs_ff;
            rbytes_in = bytes_ff;
            state_in  = bta_pkg::ST_RESP;
         end
         // free
         bta_pkg::ST_FCHK: begin
            alu_op = bta_pkg::ALU_SUB;
            alu_a  = offs_ff;
            alu_b  = D_TAG;
            pos_in = alu_res;
            if (alu_lt) begin
               stat_in   = bta_pkg::STAT_RANGE;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else begin
               state_in = bta_pkg::ST_FRANGE;
            end
         end
         bta_pkg::ST_FRANGE: begin
            alu_a = offs_ff;
            alu_b = D_TAG;
            raddr = pos_ff[AW-1:0];
            if (alu_res > D_REGION) begin
               stat_in   = bta_pkg::STAT_RANGE;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else begin
               state_in = bta_pkg::ST_FEV;
            end
         end
         bta_pkg::ST_FEV: begin
            alu_a  = pos_ff;
            alu_b  = q_size;
            nxt_in = alu_res;
            sz_in  = q_size;
            if (q_kind != bta_pkg::KIND_START || !q_occ || q_size < D_TAG2) begin
               stat_in   = bta_pkg::STAT_NO_TAG;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else begin
               state_in = bta_pkg::ST_FLIM;
            end
         end
         bta_pkg::ST_FLIM: begin
            alu_op   = bta_pkg::ALU_SUB;
            alu_a    = pos_ff;
            alu_b    = D_TAG;
            pe_in    = alu_res;
            pick_in  = pos_ff;
            bytes_in = sz_ff;
            raddr    = alu_res[AW-1:0];
            if (nxt_ff > D_REGION) begin
               stat_in   = bta_pkg::STAT_NO_TAG;
               rofs_in   = '0;
               rbytes_in = '0;
               state_in  = bta_pkg::ST_RESP;
            end else if (pos_ff >= D_TAG) begin
               state_in = bta_pkg::ST_FPREV;
            end else begin
               state_in = bta_pkg::ST_FNRD;
            end
         end
         bta_pkg::ST_FPREV: begin
            alu_op   = bta_pkg::ALU_SUB;
            alu_a    = pos_ff;
            alu_b    = q_size;
            other_in = q_size;
            if (q_kind == bta_pkg::KIND_END && !q_occ && q_size >= D_TAG2 && !alu_lt) begin
               we       = 1'b1;
               waddr    = pe_ff[AW-1:0];
               state_in = bta_pkg::ST_FPCLR;
            end else begin
               state_in = bta_pkg::ST_FNRD;
            end
         end
         bta_pkg::ST_FPCLR: begin
            we       = 1'b1;
            waddr    = pos_ff[AW-1:0];
            alu_op   = bta_pkg::ALU_SUB;
            alu_a    = pos_ff;
            alu_b    = other_ff;
            pick_in  = alu_res;
            state_in = bta_pkg::ST_FPADD;
         end
         bta_pkg::ST_FPADD: begin
            alu_a    = bytes_ff;
            alu_b    = other_ff;
            bytes_in = alu_res;
            state_in = bta_pkg::ST_FNRD;
         end
         bta_pkg::ST_FNRD: begin
            raddr    = nxt_ff[AW-1:0];
            state_in = (nxt_ff < D_REGION) ? bta_pkg::ST_FNEV : bta_pkg::ST_FHEAD;
         end
         bta_pkg::ST_FNEV: begin
            alu_a    = nxt_ff;
            alu_b    = q_size;
            other_in = q_size;
            if (q_kind == bta_pkg::KIND_START && !q_occ && q_size >= D_TAG2 &&
                alu_res <= D_REGION) begin
               state_in = bta_pkg::ST_FNCLR;
            end else begin
               state_in = bta_pkg::ST_FHEAD;
            end
         end
         bta_pkg::ST_FNCLR: begin
            alu_op   = bta_pkg::ALU_SUB;
            alu_a    = nxt_ff;
            alu_b    = D_TAG;
            we       = 1'b1;
            waddr    = alu_res[AW-1:0];
            state_in = bta_pkg::ST_FNCLR2;
         end
         bta_pkg::ST_FNCLR2: begin
            we       = 1'b1;
            waddr    = nxt_ff[AW-1:0];
            alu_a    = bytes_ff;
            alu_b    = other_ff;
            bytes_in = alu_res;
            state_in = bta_pkg::ST_FHEAD;
         end
         bta_pkg::ST_FHEAD: begin
            we       = 1'b1;
            waddr    = pick_ff[AW-1:0];
            wdata    = pack(bta_pkg::KIND_START, 1'b0, bytes_ff);
            alu_a    = pick_ff;
            alu_b    = bytes_ff;
            endp_in  = alu_res;
            state_in = bta_pkg::ST_FTAIL;
         end
         bta_pkg::ST_FTAIL: begin
            alu_op    = bta_pkg::ALU_SUB;
            alu_a     = endp_ff;
            alu_b     = D_TAG;
            we        = 1'b1;
            waddr     = alu_res[AW-1:0];
            wdata     = pack(bta_pkg::KIND_END, 1'b0, bytes_ff);
            stat_in   = bta_pkg::STAT_OK;
            rofs_in   = '0;
            rbytes_in = bytes_ff;
            state_in  = bta_pkg::ST_RESP;
         end
         bta_pkg::ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = bta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bta_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> verif/tb_boundary_tag_allocator.sv
// self-checking testbench for boundary_tag_allocator: directed and random allocate/free
// requests checked against an internal tag store predictor in a scoreboard class
// depends on bta_pkg, bta_ifs and the allocator rtl
`timescale 1ns / 100ps

module tb_boundary_tag_allocator;

   localparam int REGION  = bta_pkg::REGION_BYTES_DEF;
   localparam int TAG     = bta_pkg::TAG_BYTES_DEF;
   localparam int MIN_BLK = 2 * TAG;

   typedef struct {
      bta_pkg::status_type                status;
      logic [bta_pkg::OFFS_W-1:0]         data_offset;
      logic [bta_pkg::BYTES_W-1:0]        block_bytes;
   } alloc_result_type;

   class arena_scoreboard;
      bta_pkg::kind_type  kind [REGION];
      bit                 occ  [REGION];
      int unsigned        bsize[REGION];
      bta_pkg::fit_type   mode;
      alloc_result_type   pending[$];
      int                 errors;
      int                 n_alloc_ok, n_free_ok, n_refused, n_checked;

      function new();
         foreach (kind[i]) begin
            kind[i] = bta_pkg::KIND_NONE;
            occ[i] = 0;
            bsize[i] = 0;
         end
         mode = bta_pkg::FIT_FIRST;
         kind[0] = bta_pkg::KIND_START;
         bsize[0] = REGION;
         kind[REGION-TAG] = bta_pkg::KIND_END;
         bsize[REGION-TAG] = REGION;
      endfunction

      function void put(int unsigned pos, bta_pkg::kind_type k, bit o, int unsigned sz);
         if (pos < REGION) begin
            kind[pos] = k;
            occ[pos] = o;
            bsize[pos] = sz;
         end
      endfunction

      function alloc_result_type place(int unsigned need);
         alloc_result_type r;
         int unsigned pos, pick, psz, sz;
         bit found;
         r = '{bta_pkg::STAT_NO_FIT, '0, '0};
         pos = 0; pick = 0; psz = 0; found = 0;
         if (mode == bta_pkg::FIT_NONE || need > REGION) return r;
         while (pos < REGION) begin
            if (kind[pos] != bta_pkg::KIND_START) break;
            sz = bsize[pos];
            if (sz < MIN_BLK || sz > REGION - pos) break;
            if (!occ[pos] && sz >= need) begin
               if (!found || (mode == bta_pkg::FIT_BEST && sz < psz) ||
                   (mode == bta_pkg::FIT_WORST && sz > psz)) begin
                  pick = pos;
                  psz = sz;
                  found = 1;
               end
               if (mode == bta_pkg::FIT_FIRST) break;
            end
            pos += sz;
         end
         if (!found) return r;
         if (psz - need < MIN_BLK) begin
            put(pick, bta_pkg::KIND_START, 1, psz);
            put(pick + psz - TAG, bta_pkg::KIND_END, 1, psz);
            r = '{bta_pkg::STAT_OK, bta_pkg::OFFS_W'(pick + TAG), bta_pkg::BYTES_W'(psz)};
         end else begin
            put(pick, bta_pkg::KIND_START, 1, need);
            put(pick + need - TAG, bta_pkg::KIND_END, 1, need);
            put(pick + need, bta_pkg::KIND_START, 0, psz - need);
            put(pick + psz - TAG, bta_pkg::KIND_END, 0, psz - need);
            r = '{bta_pkg::STAT_OK, bta_pkg::OFFS_W'(pick + TAG), bta_pkg::BYTES_W'(need)};
         end
         return r;
      endfunction

      function alloc_result_type release_block(int unsigned offs);
         alloc_result_type r;
         int unsigned s, sz, start, total, pe, psz, nx, nsz;
         r = '{bta_pkg::STAT_RANGE, '0, '0};
         if (offs < TAG || offs + TAG > REGION) return r;
         s = offs - TAG;
         sz = bsize[s];
         r.status = bta_pkg::STAT_NO_TAG;
         if (kind[s] != bta_pkg::KIND_START || !occ[s] || sz < MIN_BLK || sz > REGION - s)
            return r;
         start = s;
         total = sz;
         if (s >= TAG) begin
            pe = s - TAG;
            psz = bsize[pe];
            if (kind[pe] == bta_pkg::KIND_END && !occ[pe] && psz >= MIN_BLK && psz <= s) begin
               put(pe, bta_pkg::KIND_NONE, 0, 0);
               put(s, bta_pkg::KIND_NONE, 0, 0);
               start = s - psz;
               total += psz;
            end
         end
         nx = s + sz;
         if (nx < REGION && kind[nx] == bta_pkg::KIND_START && !occ[nx]) begin
            nsz = bsize[nx];
            if (nsz >= MIN_BLK && nsz <= REGION - nx) begin
               put(nx - TAG, bta_pkg::KIND_NONE, 0, 0);
               put(nx, bta_pkg::KIND_NONE, 0, 0);
               total += nsz;
            end
         end
         put(start, bta_pkg::KIND_START, 0, total);
         put(start + total - TAG, bta_pkg::KIND_END, 0, total);
         r = '{bta_pkg::STAT_OK, '0, bta_pkg::BYTES_W'(total)};
         return r;
      endfunction

      function alloc_result_type note_request(bta_pkg::req_kind_type rt,
                                              logic [bta_pkg::ELEM_W-1:0] es,
                                              logic [bta_pkg::ELEM_W-1:0] ec,
                                              logic [bta_pkg::OFFS_W-1:0] fo);
         alloc_result_type r;
         if (rt == bta_pkg::REQ_ALLOC) begin
            r = place(int'(es) * int'(ec) + MIN_BLK);
            if (r.status == bta_pkg::STAT_OK) n_alloc_ok++;
         end else begin
            r = release_block(fo);
            if (r.status == bta_pkg::STAT_OK) n_free_ok++;
         end
         if (r.status != bta_pkg::STAT_OK) n_refused++;
         pending.insert(pending.size(), r);
         return r;
      endfunction

      function void check_result(logic [bta_pkg::STAT_W-1:0] st,
                                 logic [bta_pkg::OFFS_W-1:0] off,
                                 logic [bta_pkg::BYTES_W-1:0] by);
         alloc_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected response status=%0d offset=%0d bytes=%0d", st, off, by);
            errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (st !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, st);
            errors++;
         end
         if (off !== e.data_offset) begin
            $error("data_offset: expected %0d actual %0d", e.data_offset, off);
            errors++;
         end
         if (by !== e.block_bytes) begin
            $error("block_bytes: expected %0d actual %0d", e.block_bytes, by);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bta_req_if req_bus ();
   bta_rsp_if rsp_bus ();
   bta_csr_if csr_bus ();

   boundary_tag_allocator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   arena_scoreboard sb;
   int unsigned live[$];
   bit calm;
   bit hold_req;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_request(bta_pkg::req_kind_type rt, int es, int ec, int fo);
      alloc_result_type r;
      int idx;
      sender_gap();
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= rt;
      req_bus.elem_size   <= bta_pkg::ELEM_W'(es);
      req_bus.elem_count  <= bta_pkg::ELEM_W'(ec);
      req_bus.free_offset <= bta_pkg::OFFS_W'(fo);
      do @(posedge clock); while (!req_bus.ready);
      r = sb.note_request(rt, bta_pkg::ELEM_W'(es), bta_pkg::ELEM_W'(ec),
                          bta_pkg::OFFS_W'(fo));
      if (r.status == bta_pkg::STAT_OK) begin
         if (rt == bta_pkg::REQ_ALLOC) live.insert(live.size(), r.data_offset);
         else begin
            idx = -1;
            foreach (live[i]) if (live[i] == bta_pkg::OFFS_W'(fo)) idx = i;
            if (idx >= 0) live.delete(idx);
         end
      end
   endtask

   task automatic write_mode(bta_pkg::fit_type m);
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_bus.valid  <= 1'b1;
      csr_bus.policy <= m;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.mode = m;
   endtask

   task automatic random_request();
      int r, k;
      r = $urandom_range(0, 99);
      if (r < 50)
         send_request(bta_pkg::REQ_ALLOC, $urandom_range(1, 40), $urandom_range(1, 6), 0);
      else if (r < 85 && live.size() != 0) begin
         k = $urandom_range(0, live.size() - 1);
         send_request(bta_pkg::REQ_FREE, 0, 0, live[k]);
      end else if (r < 90)
         send_request(bta_pkg::REQ_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 8191), 0);
      else if (r < 95) send_request(bta_pkg::REQ_FREE, 0, 0, $urandom_range(0, 4095));
      else if (live.size() != 0 && r < 98) begin
         k = $urandom_range(0, live.size() - 1);
         send_request(bta_pkg::REQ_FREE, 0, 0, live[k] + $urandom_range(1, 3));
      end else
         send_request(bta_pkg::REQ_ALLOC, $urandom_range(0, 1) ? 0 : $urandom_range(0, 8191),
                      0, 0);
   endtask

   // response side: random back-pressure, one long hold-off on request
   initial begin
      bit done_hold;
      done_hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.status, rsp_bus.data_offset, rsp_bus.block_bytes);
         if (hold_req && !done_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            done_hold = 1;
            rsp_bus.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(posedge clock);
         end else
            rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      bta_pkg::fit_type modes[7];
      int               counts[7];
      sb = new();
      calm = 0;
      hold_req = 0;
      modes  = '{bta_pkg::FIT_FIRST, bta_pkg::FIT_BEST, bta_pkg::FIT_WORST, bta_pkg::FIT_NONE,
                 bta_pkg::FIT_BEST, bta_pkg::FIT_WORST, bta_pkg::FIT_FIRST};
      counts = '{400, 400, 400, 60, 300, 300, 75};
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= bta_pkg::REQ_ALLOC;
      req_bus.elem_size <= '0;
      req_bus.elem_count <= '0;
      req_bus.free_offset <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.policy <= bta_pkg::FIT_FIRST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_mode(bta_pkg::FIT_FIRST);
      // empty request, oversized product, offset range edges, bad and double free
      send_request(bta_pkg::REQ_ALLOC, 0, 5, 0);
      send_request(bta_pkg::REQ_ALLOC, 8191, 8191, 0);
      send_request(bta_pkg::REQ_FREE, 0, 0, 0);
      send_request(bta_pkg::REQ_FREE, 0, 0, 16);
      send_request(bta_pkg::REQ_FREE, 0, 0, 4080);
      send_request(bta_pkg::REQ_FREE, 0, 0, 4079);
      send_request(bta_pkg::REQ_FREE, 0, 0, 18);
      send_request(bta_pkg::REQ_FREE, 0, 0, 17);
      send_request(bta_pkg::REQ_FREE, 0, 0, 17);
      // whole arena exactly, then a remainder too small to split
      send_request(bta_pkg::REQ_ALLOC, 2, 2031, 0);
      send_request(bta_pkg::REQ_FREE, 0, 0, 17);
      send_request(bta_pkg::REQ_ALLOC, 3, 1343, 0);
      send_request(bta_pkg::REQ_FREE, 0, 0, 17);
      send_request(bta_pkg::REQ_ALLOC, 4096, 1, 0);
      send_request(bta_pkg::REQ_ALLOC, 4096, 0, 0);
      // merges on each side and on both
      send_request(bta_pkg::REQ_ALLOC, 1, 6, 0);
      send_request(bta_pkg::REQ_ALLOC, 1, 6, 0);
      send_request(bta_pkg::REQ_ALLOC, 1, 6, 0);
      send_request(bta_pkg::REQ_FREE, 0, 0, 17);
      send_request(bta_pkg::REQ_FREE, 0, 0, 131);
      send_request(bta_pkg::REQ_FREE, 0, 0, 51);
      send_request(bta_pkg::REQ_FREE, 0, 0, 91);

      for (int p = 0; p < 7; p++) begin
         write_mode(modes[p]);
         if (p == 1) hold_req = 1;
         if (p == 6) calm = 1;
         repeat (counts[p]) random_request();
      end

      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("covered %0d responses: %0d allocations, %0d frees, %0d refused",
               sb.n_checked, sb.n_alloc_ok, sb.n_free_ok, sb.n_refused);
      $display("all fit modes including the undefined one, with back-pressure and a long stall");
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
